FILE: rtl/assert_macros.svh
// Assertion helpers for the checker file pfr_checker.sv.
// Every property is sampled on the rising edge of clk and is held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the condition holds at every sampled edge.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that the antecedent implies the consequent in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the antecedent implies the consequent in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pfr_pkg.sv
`default_nettype none

package pfr_pkg;

    // Status codes of a result transaction.
    localparam logic [2:0] ST_BUSY      = 3'd0;
    localparam logic [2:0] ST_COMPLETE  = 3'd1;
    localparam logic [2:0] ST_BAD_START = 3'd2;
    localparam logic [2:0] ST_TOO_LARGE = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_START_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LIM  = 2'd2;

    localparam logic [7:0]  RST_START_FIRST  = 8'hB0;
    localparam logic [7:0]  RST_START_SECOND = 8'hB2;
    localparam logic [10:0] RST_PAYLOAD_LIM  = 11'd1024;

    localparam int HEADER_BYTES = 8;

    typedef struct packed {
        logic [7:0]  start_first;
        logic [7:0]  start_second;
        logic [10:0] payload_limit;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  data_byte;
        logic        payload_valid;
        logic        header_done;
        logic [15:0] frame_kind;
        logic [15:0] packet_count;
        logic [15:0] frame_len;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/pfr_parser.sv
`default_nettype none

module pfr_parser
    import pfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 1024
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       take,
    input  wire logic [7:0] rx_byte,
    input  wire cfg_t       cfg,
    output result_t         res
);

    localparam int OVF_COUNT = HEADER_BYTES + MAX_PAYLOAD;
    localparam int IDX_W     = $clog2(OVF_COUNT + 1);

    localparam logic [IDX_W-1:0] OVF_IDX   = IDX_W'(OVF_COUNT);
    localparam logic [IDX_W-1:0] IDX_ONE   = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_TYPE  = IDX_W'(4);
    localparam logic [IDX_W-1:0] IDX_COUNT = IDX_W'(6);
    localparam logic [IDX_W-1:0] IDX_HDR   = IDX_W'(HEADER_BYTES);
    localparam logic [15:0]      MAX_SIZE  = 16'(MAX_PAYLOAD);
    localparam logic [16:0]      HDR_WIDE  = 17'(HEADER_BYTES);

    localparam logic [2:0] PH_MARKER   = 3'd0;
    localparam logic [2:0] PH_TYPE     = 3'd1;
    localparam logic [2:0] PH_COUNT    = 3'd2;
    localparam logic [2:0] PH_SIZE     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD  = 3'd4;
    localparam logic [2:0] PH_COMPLETE = 3'd5;

    logic [2:0]       phase_reg, phase_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       first_reg, first_next;
    logic [15:0]      type_reg, type_next;
    logic [15:0]      count_reg, count_next;
    logic [15:0]      size_reg, size_next;
    logic             hdr_reg, hdr_next;
    logic [15:0]      limit_eff;
    logic [15:0]      limit_cfg;

    // Saturate the configured limit at the built maximum.
    assign limit_cfg = {5'd0, cfg.payload_limit};
    assign limit_eff = (limit_cfg > MAX_SIZE) ? MAX_SIZE : limit_cfg;

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        first_next = first_reg;
        type_next  = type_reg;
        count_next = count_reg;
        size_next  = size_reg;
        hdr_next   = hdr_reg;
        res.status        = ST_BUSY;
        res.payload_valid = 1'b0;

        if (take)
        begin
            // A finished packet restarts before the new byte is parsed.
            if (phase_reg == PH_COMPLETE)
            begin
                phase_next = PH_MARKER;
                idx_next   = '0;
                first_next = '0;
                type_next  = '0;
                count_next = '0;
                size_next  = '0;
                hdr_next   = 1'b0;
            end

            if (idx_next >= OVF_IDX)
            begin
                res.status = ST_OVERFLOW;
            end
            else
            begin
                idx_next = idx_next + IDX_ONE;
                case (phase_next)
                    PH_MARKER:
                    begin
                        if (idx_next == IDX_ONE)
                        begin
                            first_next = rx_byte;
                        end
                        else if (first_next != cfg.start_first ||
                                 rx_byte != cfg.start_second)
                        begin
                            phase_next = PH_MARKER;
                            idx_next   = '0;
                            first_next = '0;
                            type_next  = '0;
                            count_next = '0;
                            size_next  = '0;
                            hdr_next   = 1'b0;
                            res.status = ST_BAD_START;
                        end
                        else
                        begin
                            phase_next = PH_TYPE;
                        end
                    end
                    PH_TYPE:
                    begin
                        type_next = {type_next[7:0], rx_byte};
                        if (idx_next == IDX_TYPE)
                        begin
                            phase_next = PH_COUNT;
                        end
                    end
                    PH_COUNT:
                    begin
                        count_next = {count_next[7:0], rx_byte};
                        if (idx_next == IDX_COUNT)
                        begin
                            phase_next = PH_SIZE;
                        end
                    end
                    PH_SIZE:
                    begin
                        size_next = {size_next[7:0], rx_byte};
                        if (idx_next == IDX_HDR)
                        begin
                            if (size_next > limit_eff)
                            begin
                                phase_next = PH_MARKER;
                                idx_next   = '0;
                                first_next = '0;
                                type_next  = '0;
                                count_next = '0;
                                size_next  = '0;
                                hdr_next   = 1'b0;
                                res.status = ST_TOO_LARGE;
                            end
                            else
                            begin
                                hdr_next = 1'b1;
                                if (size_next == 16'd0)
                                begin
                                    phase_next = PH_COMPLETE;
                                    res.status = ST_COMPLETE;
                                end
                                else
                                begin
                                    phase_next = PH_PAYLOAD;
                                end
                            end
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        res.payload_valid = 1'b1;
                        if (17'(idx_next) >= ({1'b0, size_next} + HDR_WIDE))
                        begin
                            phase_next = PH_COMPLETE;
                            res.status = ST_COMPLETE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        res.data_byte    = rx_byte;
        res.header_done  = hdr_next;
        res.frame_kind   = type_next;
        res.packet_count = count_next;
        res.frame_len    = size_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MARKER;
            idx_reg   <= '0;
            first_reg <= '0;
            type_reg  <= '0;
            count_reg <= '0;
            size_reg  <= '0;
            hdr_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            first_reg <= first_next;
            type_reg  <= type_next;
            count_reg <= count_next;
            size_reg  <= size_next;
            hdr_reg   <= hdr_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/packet_frame_receiver.sv
// Byte-serial deframer for length-prefixed packets.
// Input channel: in_valid / in_ready carry one received byte (rx_byte) per transaction.
// Output channel: out_valid / out_ready carry one result transaction per input byte:
//   status, the echoed data_byte, payload_valid, header_done and the captured
//   frame_kind, packet_count and frame_len fields.
// A packet is two start marker bytes, big-endian type, count and size, then payload.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 first marker,
//   1 second marker, 2 payload limit); other indexes are ignored. Write only while idle.
// Result path: a result is valid in the cycle after its byte is accepted, unless the
//   output register still holds an untaken result; then it waits in the skid register.
// Throughput: one byte per cycle while in_ready is high; the parse is a single
//   compare-and-update pass between the parser state registers and the output register.
// Stalls: a two-entry output stage (output register plus skid register) absorbs a
//   stalled receiver; in_ready drops only when both entries hold results.
// Reset (rst_n low, asynchronous): parser returns to the start marker phase with all
//   captured fields zero, configuration returns to 0xB0 / 0xB2 / 1024, and both
//   output entries are emptied.
`default_nettype none

module packet_frame_receiver
    import pfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 1024
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [7:0]            rx_byte,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [2:0]                 status,
    output logic [7:0]                 data_byte,
    output logic                       payload_valid,
    output logic                       header_done,
    output logic [15:0]                frame_kind,
    output logic [15:0]                packet_count,
    output logic [15:0]                frame_len,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg_reg;
    result_t new_res;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    in_take;
    logic    out_take;

    assign in_ready = !skid_valid_reg;
    assign in_take  = in_valid && in_ready;
    assign out_take = out_valid_reg && out_ready;

    // Configuration registers; a write to an unused index is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_first   <= RST_START_FIRST;
            cfg_reg.start_second  <= RST_START_SECOND;
            cfg_reg.payload_limit <= RST_PAYLOAD_LIM;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_FIRST:  cfg_reg.start_first   <= cfg_data[7:0];
                CFG_START_SECOND: cfg_reg.start_second  <= cfg_data[7:0];
                CFG_PAYLOAD_LIM:  cfg_reg.payload_limit <= cfg_data;
                default:          ;
            endcase
        end
    end

    pfr_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (in_take),
        .rx_byte (rx_byte),
        .cfg     (cfg_reg),
        .res     (new_res)
    );

    // Output stage valid bits: advance the skid entry when the head is taken,
    // otherwise land a new result in the head if it frees up, else hold it in skid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_take)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload of the output stage, no reset needed.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_take)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_reg <= new_res;
            end
            else
            begin
                out_reg <= new_res;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_reg.status;
    assign data_byte     = out_reg.data_byte;
    assign payload_valid = out_reg.payload_valid;
    assign header_done   = out_reg.header_done;
    assign frame_kind    = out_reg.frame_kind;
    assign packet_count  = out_reg.packet_count;
    assign frame_len     = out_reg.frame_len;

endmodule

`default_nettype wire

FILE: rtl/pfr_checker.sv
`default_nettype none
`include "assert_macros.svh"

module pfr_checker
    import pfr_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [7:0]  rx_byte,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  status,
    input wire logic [7:0]  data_byte,
    input wire logic        payload_valid,
    input wire logic        header_done,
    input wire logic [15:0] frame_kind,
    input wire logic [15:0] packet_count,
    input wire logic [15:0] frame_len
);

    logic in_take;
    logic body_or_done;
    logic is_error;
    logic fields_clear;
    logic out_stall;

    assign in_take      = in_valid && in_ready;
    assign body_or_done = out_valid && (payload_valid || status == ST_COMPLETE);
    assign is_error     = out_valid && (status == ST_BAD_START || status == ST_TOO_LARGE);
    assign fields_clear = !header_done && !payload_valid && frame_kind == 16'd0 &&
                          packet_count == 16'd0 && frame_len == 16'd0;
    assign out_stall    = out_valid && !out_ready;

    // A payload byte or a completed packet always follows an accepted header.
    `ASSERT_SAME(a_payload_after_header, body_or_done, header_done, "payload without header")

    // An error clears the parser, so its captured fields read as zero.
    `ASSERT_SAME(a_error_clears, is_error, fields_clear, "error result carries captured fields")

    // A completed packet restarts first, so overflow never shows.
    `ASSERT_ALWAYS(a_no_overflow, !(out_valid && status == ST_OVERFLOW), "overflow status reported")

    // A byte taken into an empty output stage shows up the next cycle, echoed.
    `ASSERT_NEXT(a_latency, in_take && !out_valid, out_valid && data_byte == $past(rx_byte), "late result")

    // A stalled result holds.
    `ASSERT_NEXT(a_stall_hold, out_stall, out_valid && $stable(status) && $stable(data_byte), "stall changed")

endmodule

bind packet_frame_receiver pfr_checker u_pfr_checker (.*);

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pfr_pkg::*;

    // Built payload maximum of the instance under test.
    localparam int PAYLOAD_MAX = 1024;

    // Index 3 decodes to no register; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Print at most this many mismatch lines; keep counting past it.
    localparam int MAX_REPORTS = 40;

    // Parse phases of the frame tracker.
    typedef enum logic [2:0] {
        SEEK_MARKER,
        GET_TYPE,
        GET_COUNT,
        GET_SIZE,
        GET_PAYLOAD,
        FRAME_DONE
    } frame_phase_t;

    // Clock, reset and every block input start at a known value.
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic [7:0]            rx_byte   = 8'h00;
    logic                  out_ready = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_START_FIRST;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic        in_ready;
    logic        out_valid;
    logic [2:0]  status;
    logic [7:0]  data_byte;
    logic        payload_valid;
    logic        header_done;
    logic [15:0] frame_kind;
    logic [15:0] packet_count;
    logic [15:0] frame_len;

    // Mirror of the configuration registers, at their reset values.
    logic [7:0]  cfg_first  = RST_START_FIRST;
    logic [7:0]  cfg_second = RST_START_SECOND;
    logic [10:0] cfg_limit  = RST_PAYLOAD_LIM;

    // Frame tracker state, mirrors the parser registers of the block.
    frame_phase_t fr_phase      = SEEK_MARKER;
    logic [10:0]  fr_index      = '0;
    logic [7:0]   fr_first_mark = '0;
    logic [15:0]  fr_type       = '0;
    logic [15:0]  fr_count      = '0;
    logic [15:0]  fr_size       = '0;
    logic         fr_header     = 1'b0;

    // One entry per accepted byte, oldest first.
    result_t pending_results[$];
    result_t want;

    int mismatch_count = 0;

    // Idle controls: the sender and the receiver insert random gaps when set.
    bit tx_idle_on   = 1'b1;
    bit rx_idle_on   = 1'b1;
    int rx_hold_left = 0;
    int rx_gap_left  = 0;
    int rx_pick;

    packet_frame_receiver #(
        .MAX_PAYLOAD (PAYLOAD_MAX)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .data_byte     (data_byte),
        .payload_valid (payload_valid),
        .header_done   (header_done),
        .frame_kind    (frame_kind),
        .packet_count  (packet_count),
        .frame_len     (frame_len),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Give up after a generous bound; a correct run needs a small fraction of it.
    initial
    begin
        #10ms;
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Frame tracker
    // ------------------------------------------------------------------

    // Drop any partial frame and return to marker search.
    function automatic void clear_frame();
        fr_phase      = SEEK_MARKER;
        fr_index      = '0;
        fr_first_mark = '0;
        fr_type       = '0;
        fr_count      = '0;
        fr_size       = '0;
        fr_header     = 1'b0;
    endfunction

    // Payload limit in force: the register, saturated at the built maximum.
    function automatic int limit_now();
        return (int'(cfg_limit) > PAYLOAD_MAX) ? PAYLOAD_MAX : int'(cfg_limit);
    endfunction

    // Advance the tracker by one received byte and return the result it causes.
    function automatic result_t deframe_byte(input logic [7:0] b);
        result_t r;
        r               = '0;
        r.status        = ST_BUSY;
        r.data_byte     = b;

        // A byte after a finished frame opens a fresh one.
        if (fr_phase == FRAME_DONE)
            clear_frame();

        if (int'(fr_index) >= HEADER_BYTES + PAYLOAD_MAX)
        begin
            r.status = ST_OVERFLOW;
        end
        else
        begin
            fr_index = fr_index + 11'd1;
            case (fr_phase)
                SEEK_MARKER:
                begin
                    // Hold the first byte; judge both once the second is in.
                    if (fr_index == 11'd1)
                    begin
                        fr_first_mark = b;
                    end
                    else if (fr_first_mark != cfg_first || b != cfg_second)
                    begin
                        clear_frame();
                        r.status = ST_BAD_START;
                    end
                    else
                    begin
                        fr_phase = GET_TYPE;
                    end
                end
                GET_TYPE:
                begin
                    fr_type = {fr_type[7:0], b};
                    if (fr_index == 11'd4)
                        fr_phase = GET_COUNT;
                end
                GET_COUNT:
                begin
                    fr_count = {fr_count[7:0], b};
                    if (fr_index == 11'd6)
                        fr_phase = GET_SIZE;
                end
                GET_SIZE:
                begin
                    fr_size = {fr_size[7:0], b};
                    if (int'(fr_index) == HEADER_BYTES)
                    begin
                        if (int'(fr_size) > limit_now())
                        begin
                            clear_frame();
                            r.status = ST_TOO_LARGE;
                        end
                        else
                        begin
                            fr_header = 1'b1;
                            if (fr_size == 16'd0)
                            begin
                                // Empty payload: the frame ends on its last header byte.
                                fr_phase = FRAME_DONE;
                                r.status = ST_COMPLETE;
                            end
                            else
                            begin
                                fr_phase = GET_PAYLOAD;
                            end
                        end
                    end
                end
                GET_PAYLOAD:
                begin
                    r.payload_valid = 1'b1;
                    if (int'(fr_index) >= HEADER_BYTES + int'(fr_size))
                    begin
                        fr_phase = FRAME_DONE;
                        r.status = ST_COMPLETE;
                    end
                end
                default:
                begin
                end
            endcase
        end

        r.header_done  = fr_header;
        r.frame_kind   = fr_type;
        r.packet_count = fr_count;
        r.frame_len    = fr_size;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_REPORTS)
            $display("MISMATCH at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] exp);
        if (got !== exp)
            report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, exp));
    endtask

    // Predict on every accepted byte; compare every accepted result with the
    // oldest prediction. Everything here samples values from before the edge.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            pending_results.push_back(deframe_byte(rx_byte));

        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result transaction with nothing pending");
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status",        16'(status),        16'(want.status));
                check_field("data_byte",     16'(data_byte),     16'(want.data_byte));
                check_field("payload_valid", 16'(payload_valid), 16'(want.payload_valid));
                check_field("header_done",   16'(header_done),   16'(want.header_done));
                check_field("frame_kind",    frame_kind,         want.frame_kind);
                check_field("packet_count",  packet_count,       want.packet_count);
                check_field("frame_len",     frame_len,          want.frame_len);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Gap length: mostly none or short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Result sink: honor a requested hold first, then random stalls.
    always @(posedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            out_ready <= 1'b0;
            rx_hold_left--;
        end
        else if (rx_gap_left > 0)
        begin
            out_ready <= 1'b0;
            rx_gap_left--;
        end
        else
        begin
            rx_pick = rx_idle_on ? gap_len() : 0;
            if (rx_pick > 0)
            begin
                out_ready   <= 1'b0;
                rx_gap_left = rx_pick - 1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Offer one byte and hold it until the transaction completes. Valid is
    // dropped only for a gap, so back-to-back bytes keep it high.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_idle_on ? gap_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Send a header with the given fields, then n_pay random payload bytes.
    task automatic send_frame(input logic [7:0] m1, input logic [7:0] m2,
                              input logic [15:0] typ, input logic [15:0] cnt,
                              input logic [15:0] siz, input int n_pay);
        send_byte(m1);
        send_byte(m2);
        send_byte(typ[15:8]);
        send_byte(typ[7:0]);
        send_byte(cnt[15:8]);
        send_byte(cnt[7:0]);
        send_byte(siz[15:8]);
        send_byte(siz[7:0]);
        repeat (n_pay) send_byte(8'($urandom));
    endtask

    // Stop offering and wait until every pending result has been taken.
    // The first edge lets the prediction of the last byte land in the queue.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all registers back to back, plus one write to the unused index.
    // Marker writes carry random upper bits, which the block must drop.
    task automatic load_config(input logic [7:0] first, input logic [7:0] second,
                               input logic [10:0] lim);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_START_FIRST;
        cfg_data  <= {3'($urandom_range(0, 7)), first};
        @(posedge clk);
        cfg_index <= CFG_START_SECOND;
        cfg_data  <= {3'($urandom_range(0, 7)), second};
        @(posedge clk);
        cfg_index <= CFG_PAYLOAD_LIM;
        cfg_data  <= lim;
        @(posedge clk);
        cfg_index <= CFG_UNUSED;
        cfg_data  <= CFG_DATA_W'($urandom);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_first  = first;
        cfg_second = second;
        cfg_limit  = lim;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty payload with all-ones type and count: completes on the last header byte.
    task automatic test_zero_size();
        send_frame(cfg_first, cfg_second, 16'hFFFF, 16'hFFFF, 16'h0000, 0);
    endtask

    // Frame of size one, then its one payload byte, which is echoed.
    task automatic test_payload_echo();
        send_frame(cfg_first, cfg_second, 16'h0000, 16'h0000, 16'h0001, 0);
        send_byte(8'hFF);
    endtask

    // Bad first marker, then bad second marker.
    task automatic test_bad_marker();
        send_byte(8'h00);
        send_byte(cfg_second);
        send_byte(cfg_first);
        send_byte(~cfg_second);
    endtask

    // Size one above the limit clears the frame.
    task automatic test_size_limit();
        send_frame(cfg_first, cfg_second, 16'h1234, 16'h5678,
                   16'(limit_now() + 1), 0);
    endtask

    // Largest payload a reduced limit allows.
    task automatic test_max_payload();
        wait_drained();
        load_config(cfg_first, cfg_second, 11'd40);
        send_frame(cfg_first, cfg_second, 16'h8001, 16'h7FFE,
                   16'(limit_now()), limit_now());
    endtask

    // Hold off the sink for a long stretch while bytes keep coming, so both
    // output entries fill and in_ready drops; then pause until all is drained.
    task automatic test_backpressure();
        wait_drained();
        tx_idle_on   = 1'b0;
        rx_hold_left = 120;
        send_frame(cfg_first, cfg_second, 16'hA5A5, 16'h5A5A, 16'd12, 12);
        send_frame(cfg_first, cfg_second, 16'h0F0F, 16'hF0F0, 16'd6, 6);
        tx_idle_on = 1'b1;
        wait_drained();
    endtask

    // Pick a size: mostly small, sometimes at the limit (or 13 to 64 when the limit
    // is above 64) or just past it, sometimes anything too large.
    function automatic int pick_size(input int lim);
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return 0;
        if (r < 7)
            return $urandom_range(1, 12);
        if (r == 7)
            return (lim <= 64) ? lim : $urandom_range(13, 64);
        if (r == 8)
            return lim + 1;
        return $urandom_range(lim + 1, 65535);
    endfunction

    // One configuration setting followed by a run of mostly well-formed frames.
    // Noise comes in pairs so the marker search stays aligned with frame starts.
    task automatic run_phase(input logic [7:0] first, input logic [7:0] second,
                             input logic [10:0] lim, input bit tx_idle,
                             input bit rx_idle, input int budget);
        int         sent;
        int         pick;
        int         siz;
        int         n_pay;
        logic [7:0] m1;
        logic [7:0] m2;
        wait_drained();
        load_config(first, second, lim);
        tx_idle_on = tx_idle;
        rx_idle_on = rx_idle;
        sent = 0;
        while (sent < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                repeat (2 * $urandom_range(1, 2))
                begin
                    send_byte(8'($urandom));
                    sent++;
                end
            end
            else
            begin
                m1  = cfg_first;
                m2  = cfg_second;
                siz = pick_size(limit_now());
                n_pay = (siz <= limit_now()) ? siz : 0;
                if (pick < 22)
                begin
                    // Corrupt one marker byte; the rest of the header is noise.
                    if ($urandom_range(0, 1))
                        m1 = m1 ^ 8'($urandom_range(1, 255));
                    else
                        m2 = m2 ^ 8'($urandom_range(1, 255));
                    n_pay = 0;
                end
                send_frame(m1, m2, 16'($urandom), 16'($urandom), 16'(siz), n_pay);
                sent += HEADER_BYTES + n_pay;
            end
        end
    endtask

    // Sweep settings: defaults, extreme markers with zero limit and no idling,
    // a limit above the built maximum, then random markers with a small limit.
    task automatic test_random_traffic();
        run_phase(RST_START_FIRST, RST_START_SECOND, RST_PAYLOAD_LIM, 1'b1, 1'b1, 130);
        run_phase(8'h00, 8'hFF, 11'd0, 1'b0, 1'b0, 130);
        run_phase(8'hFF, 8'h00, 11'd2047, 1'b1, 1'b1, 130);
        run_phase(8'($urandom), 8'($urandom), 11'($urandom_range(1, 40)),
                  1'b1, 1'b1, 140);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_zero_size();
        test_payload_echo();
        test_bad_marker();
        test_size_limit();
        test_max_payload();
        test_backpressure();
        test_random_traffic();

        // Drain, then allow a few more cycles for any stray result.
        wait_drained();
        repeat (20) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("predictions left without a result");

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/pfr_pkg.sv
rtl/pfr_parser.sv
rtl/packet_frame_receiver.sv
rtl/pfr_checker.sv
tb/tb_top.sv
